/* rtl/parallel_biquad_equalizer_defines.svh */
// ----------------------------------------------------------------------------
// Parallel biquad equalizer assertion macros
// Shared assertion forms for the equalizer modules.
// ----------------------------------------------------------------------------
`ifndef PARALLEL_BIQUAD_EQUALIZER_DEFINES_SVH
`define PARALLEL_BIQUAD_EQUALIZER_DEFINES_SVH

// Checks a condition in the same cycle as its trigger.
`define PEQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("peq: same-cycle check failed");

// Checks a condition in the cycle after its trigger.
`define PEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("peq: next-cycle check failed");

`endif

/* rtl/peq_pkg.sv */
// ----------------------------------------------------------------------------
// Parallel biquad equalizer package
// Constants, types and saturation helpers shared by the equalizer modules.
// ----------------------------------------------------------------------------
package peq_pkg;

    localparam int DEF_NUM_BANDS    = 4;
    localparam int DEF_NUM_CHANNELS = 2;

    localparam int COEFS_PER_FILTER = 5;
    localparam int FILT_HPF         = 0;
    localparam int FILT_LPF         = 1;
    localparam int FIRST_BAND       = 2;
    localparam int MAX_ACTIVE_BANDS = 4;
    localparam int SUM_W            = 36;

    localparam int APB_AW = 5;
    localparam int APB_DW = 32;

    localparam logic [2:0] REG_HPF_ON     = 3'd0;
    localparam logic [2:0] REG_LPF_ON     = 3'd1;
    localparam logic [2:0] REG_BAND_MASK  = 3'd2;
    localparam logic [2:0] REG_CH_USED    = 3'd3;
    localparam logic [2:0] REG_COEF_INDEX = 3'd4;
    localparam logic [2:0] REG_COEF_WORD  = 3'd5;

    localparam logic [2:0] K_B0 = 3'd0;
    localparam logic [2:0] K_B1 = 3'd1;
    localparam logic [2:0] K_B2 = 3'd2;
    localparam logic [2:0] K_A1 = 3'd3;
    localparam logic [2:0] K_A2 = 3'd4;

    typedef logic [2:0] t_step;

    localparam t_step STEP_ISSUE  = 3'd0;
    localparam t_step STEP_MUL_B0 = 3'd1;
    localparam t_step STEP_ROUND  = 3'd2;
    localparam t_step STEP_FB1    = 3'd3;
    localparam t_step STEP_S1     = 3'd4;
    localparam t_step STEP_FF2    = 3'd5;
    localparam t_step STEP_WB     = 3'd6;

    localparam logic signed [47:0] SAT48_MAX  = {1'b0, {47{1'b1}}};
    localparam logic signed [47:0] SAT48_MIN  = {1'b1, {47{1'b0}}};
    localparam logic signed [31:0] SAT32_MAX  = {1'b0, {31{1'b1}}};
    localparam logic signed [31:0] SAT32_MIN  = {1'b1, {31{1'b0}}};
    localparam logic signed [23:0] SAT24_MAX  = {1'b0, {23{1'b1}}};
    localparam logic signed [23:0] SAT24_MIN  = {1'b1, {23{1'b0}}};
    localparam logic signed [56:0] ROUND_HALF = 57'sd65536;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_DONE = 3'b100
    } t_seq_state;

    typedef struct packed {
        logic       hpf_on;
        logic       lpf_on;
        logic [3:0] band_mask;
        logic [1:0] channels_used;
    } t_cfg;

    typedef struct packed {
        logic  load_in;
        logic  run;
        t_step step;
        logic  band;
        logic  load_out;
    } t_mac_ctl;

    function automatic logic signed [47:0] sat48(input logic signed [56:0] v);
        logic signed [47:0] r;
        if (v[56:47] == {10{v[56]}}) begin
            r = v[47:0];
        end else begin
            r = v[56] ? SAT48_MIN : SAT48_MAX;
        end
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
        logic signed [31:0] r;
        if (v[39:31] == {9{v[39]}}) begin
            r = v[31:0];
        end else begin
            r = v[39] ? SAT32_MIN : SAT32_MAX;
        end
        return r;
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [SUM_W:0] v);
        logic signed [23:0] r;
        if (v[SUM_W:23] == {(SUM_W - 22){v[SUM_W]}}) begin
            r = v[23:0];
        end else begin
            r = v[SUM_W] ? SAT24_MIN : SAT24_MAX;
        end
        return r;
    endfunction

    // The coefficient fetched in a step feeds the multiplier in the next step.
    function automatic logic [2:0] coef_sel(input t_step step);
        logic [2:0] k;
        case (step)
            STEP_ISSUE:  k = K_B0;
            STEP_MUL_B0: k = K_B1;
            STEP_ROUND:  k = K_A1;
            STEP_FB1:    k = K_B2;
            STEP_S1:     k = K_A2;
            default:     k = K_B0;
        endcase
        return k;
    endfunction

endpackage

/* rtl/peq_cfg.sv */
// ----------------------------------------------------------------------------
// Equalizer configuration registers
// APB register file and the coefficient memory with a registered read port.
// ----------------------------------------------------------------------------
module peq_cfg
    import peq_pkg::*;
#(
    parameter int NUM_BANDS = DEF_NUM_BANDS,
    localparam int COEF_DEPTH = (FIRST_BAND + NUM_BANDS) * COEFS_PER_FILTER,
    localparam int COEF_AW    = $clog2(COEF_DEPTH)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [APB_AW-1:0]         paddr,
    input  logic [APB_DW-1:0]         pwdata,
    output logic [APB_DW-1:0]         prdata,
    output logic                      pready,
    output t_cfg                      o_cfg,
    input  logic [COEF_AW-1:0]        i_coef_addr,
    output logic signed [31:0]        o_coef
);

    logic              wr_en;
    logic [2:0]        reg_sel;
    logic              r_hpf_on;
    logic              r_lpf_on;
    logic [3:0]        r_band_mask;
    logic [1:0]        r_ch_used;
    logic [4:0]        r_coef_index;
    logic [31:0]       r_coef_word;
    logic [31:0]       coef_mem [COEF_DEPTH];
    logic signed [31:0] r_coef_q;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_sel = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hpf_on     <= 1'b0;
            r_lpf_on     <= 1'b0;
            r_band_mask  <= 4'd0;
            r_ch_used    <= 2'd2;
            r_coef_index <= 5'd0;
            r_coef_word  <= 32'd0;
        end else if (wr_en) begin
            case (reg_sel)
                REG_HPF_ON:     r_hpf_on     <= pwdata[0];
                REG_LPF_ON:     r_lpf_on     <= pwdata[0];
                REG_BAND_MASK:  r_band_mask  <= pwdata[3:0];
                REG_CH_USED:    r_ch_used    <= pwdata[1:0];
                REG_COEF_INDEX: r_coef_index <= pwdata[4:0];
                REG_COEF_WORD:  r_coef_word  <= pwdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en && (reg_sel == REG_COEF_WORD) && (32'(r_coef_index) < COEF_DEPTH)) begin
            coef_mem[COEF_AW'(r_coef_index)] <= pwdata;
        end
        r_coef_q <= coef_mem[i_coef_addr];
    end

    always_comb begin
        case (reg_sel)
            REG_HPF_ON:     prdata = {31'd0, r_hpf_on};
            REG_LPF_ON:     prdata = {31'd0, r_lpf_on};
            REG_BAND_MASK:  prdata = {28'd0, r_band_mask};
            REG_CH_USED:    prdata = {30'd0, r_ch_used};
            REG_COEF_INDEX: prdata = {27'd0, r_coef_index};
            REG_COEF_WORD:  prdata = r_coef_word;
            default:        prdata = '0;
        endcase
    end

    assign o_cfg.hpf_on        = r_hpf_on;
    assign o_cfg.lpf_on        = r_lpf_on;
    assign o_cfg.band_mask     = r_band_mask;
    assign o_cfg.channels_used = r_ch_used;
    assign o_coef              = r_coef_q;

endmodule

/* rtl/peq_mac.sv */
// ----------------------------------------------------------------------------
// Equalizer multiply-accumulate datapath
// Shared 32x32 multiplier, biquad accumulator, filter state rows and band sum.
// ----------------------------------------------------------------------------
module peq_mac
    import peq_pkg::*;
#(
    parameter int NUM_BANDS    = DEF_NUM_BANDS,
    parameter int NUM_CHANNELS = DEF_NUM_CHANNELS,
    localparam int FILTERS = FIRST_BAND + NUM_BANDS,
    localparam int ROWS    = FILTERS * NUM_CHANNELS,
    localparam int ROW_AW  = $clog2(ROWS)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_mac_ctl             i_ctl,
    input  logic [ROW_AW-1:0]    i_row,
    input  logic signed [31:0]   i_coef,
    input  logic signed [23:0]   i_in_sample,
    output logic signed [23:0]   o_out_sample
);

    logic signed [31:0]      r_d;
    logic signed [SUM_W-1:0] r_sum;
    logic signed [63:0]      r_prod;
    logic signed [31:0]      r_y;
    logic signed [56:0]      r_acc;
    logic signed [47:0]      r_s1;
    logic [95:0]             row_mem [ROWS];
    logic [95:0]             r_row_q;
    logic [ROWS-1:0]         r_row_ok;
    logic                    r_row_vld;
    logic signed [23:0]      r_out_sample;

    logic signed [31:0]      mul_op;
    logic signed [54:0]      p40;
    logic signed [47:0]      s1_old;
    logic signed [47:0]      s2_old;
    logic signed [56:0]      y_sum;
    logic signed [39:0]      y40;
    logic signed [31:0]      y_new;
    logic signed [56:0]      acc_diff;
    logic signed [47:0]      s_new;
    logic signed [SUM_W:0]   total;

    always_comb begin
        mul_op   = ((i_ctl.step == STEP_FB1) || (i_ctl.step == STEP_FF2)) ? r_y : r_d;
        p40      = r_prod[63:9];
        s1_old   = r_row_vld ? r_row_q[95:48] : '0;
        s2_old   = r_row_vld ? r_row_q[47:0] : '0;
        y_sum    = 57'(p40) + 57'(s1_old) + ROUND_HALF;
        y40      = y_sum[56:17];
        y_new    = sat32(y40);
        acc_diff = r_acc - 57'(p40);
        s_new    = sat48(acc_diff);
        total    = (SUM_W + 1)'(r_sum) + (SUM_W + 1)'(r_d);
    end

    always_ff @(posedge i_clk) begin
        r_prod <= i_coef * mul_op;
        if (i_ctl.load_in) begin
            r_d   <= 32'(i_in_sample);
            r_sum <= '0;
        end
        if (i_ctl.run) begin
            case (i_ctl.step)
                STEP_ROUND: r_y   <= y_new;
                STEP_FB1:   r_acc <= 57'(p40) + 57'(s2_old);
                STEP_S1:    r_s1  <= s_new;
                STEP_FF2:   r_acc <= 57'(p40);
                STEP_WB: begin
                    if (i_ctl.band) begin
                        r_sum <= r_sum + SUM_W'(r_y) - SUM_W'(r_d);
                    end else begin
                        r_d <= r_y;
                    end
                end
                default: ;
            endcase
        end
        if (i_ctl.load_out) begin
            r_out_sample <= sat24(total);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.run && (i_ctl.step == STEP_WB)) begin
            row_mem[i_row] <= {r_s1, s_new};
        end
        r_row_q <= row_mem[i_row];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_ok  <= '0;
            r_row_vld <= 1'b0;
        end else begin
            r_row_vld <= r_row_ok[i_row];
            if (i_ctl.run && (i_ctl.step == STEP_WB)) begin
                r_row_ok[i_row] <= 1'b1;
            end
        end
    end

    assign o_out_sample = r_out_sample;

endmodule

/* rtl/peq_seq.sv */
// ----------------------------------------------------------------------------
// Equalizer sequencer
// Takes samples, walks the enabled filters through the seven-step biquad
// schedule and hands finished samples to the output register.
// ----------------------------------------------------------------------------
`include "parallel_biquad_equalizer_defines.svh"

module peq_seq
    import peq_pkg::*;
#(
    parameter int NUM_BANDS    = DEF_NUM_BANDS,
    parameter int NUM_CHANNELS = DEF_NUM_CHANNELS,
    localparam int FILTERS    = FIRST_BAND + NUM_BANDS,
    localparam int FILT_W     = $clog2(FILTERS),
    localparam int COEF_DEPTH = FILTERS * COEFS_PER_FILTER,
    localparam int COEF_AW    = $clog2(COEF_DEPTH),
    localparam int ROWS       = FILTERS * NUM_CHANNELS,
    localparam int ROW_AW     = $clog2(ROWS)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_in_channel,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic                o_out_channel,
    input  t_cfg                i_cfg,
    output logic [COEF_AW-1:0]  o_coef_addr,
    output logic [ROW_AW-1:0]   o_row,
    output t_mac_ctl            o_ctl
);

    t_seq_state         r_state;
    t_seq_state         n_state;
    logic [FILTERS-1:0] r_pend;
    logic [FILTERS-1:0] n_pend;
    logic [FILTERS-1:0] en;
    t_step              r_step;
    t_step              n_step;
    logic               r_ch;
    logic               r_out_valid;
    logic               n_out_valid;
    logic               r_out_channel;
    logic [FILT_W-1:0]  filt;
    logic               filtered;
    logic               out_free;

    for (genvar g = 0; g < FILTERS; g++) begin : g_en
        if (g == FILT_HPF) begin : g_hpf
            assign en[g] = i_cfg.hpf_on;
        end else if (g == FILT_LPF) begin : g_lpf
            assign en[g] = i_cfg.lpf_on;
        end else if (g - FIRST_BAND < MAX_ACTIVE_BANDS) begin : g_band
            assign en[g] = i_cfg.band_mask[g - FIRST_BAND];
        end else begin : g_off
            assign en[g] = 1'b0;
        end
    end

    always_comb begin
        filt = '0;
        for (int f = FILTERS - 1; f >= 0; f--) begin
            if (r_pend[f]) begin
                filt = FILT_W'(f);
            end
        end
    end

    assign filtered = ({1'b0, i_in_channel} < i_cfg.channels_used)
                   && (32'(i_in_channel) < NUM_CHANNELS);
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state        = r_state;
        n_pend         = r_pend;
        n_step         = r_step;
        o_ctl.load_in  = 1'b0;
        o_ctl.run      = 1'b0;
        o_ctl.step     = r_step;
        o_ctl.band     = (32'(filt) >= FIRST_BAND);
        o_ctl.load_out = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state       = S_RUN;
                    n_pend        = filtered ? en : '0;
                    n_step        = STEP_ISSUE;
                    o_ctl.load_in = 1'b1;
                end
            end
            S_RUN: begin
                if (r_pend == '0) begin
                    if (out_free) begin
                        o_ctl.load_out = 1'b1;
                        n_state        = S_IDLE;
                    end else begin
                        n_state = S_DONE;
                    end
                end else begin
                    o_ctl.run = 1'b1;
                    if (r_step == STEP_WB) begin
                        n_step = STEP_ISSUE;
                        n_pend = r_pend & ~(FILTERS'(1) << filt);
                    end else begin
                        n_step = r_step + 3'd1;
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    o_ctl.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_ctl.load_out) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pend      <= '0;
            r_step      <= STEP_ISSUE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pend      <= n_pend;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ctl.load_in) begin
            r_ch <= i_in_channel;
        end
        if (o_ctl.load_out) begin
            r_out_channel <= r_ch;
        end
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_out_channel = r_out_channel;
    assign o_coef_addr   = COEF_AW'(COEF_AW'(filt) * COEF_AW'(COEFS_PER_FILTER)
                         + COEF_AW'(coef_sel(r_step)));
    assign o_row         = ROW_AW'(ROW_AW'(filt) * ROW_AW'(NUM_CHANNELS) + ROW_AW'(r_ch));

    `PEQ_ASSERT_NOW(a_no_overwrite, i_clk, i_rst_n, o_ctl.load_out, !(r_out_valid && i_out_stall))
    `PEQ_ASSERT_NEXT(a_pend_shrinks, i_clk, i_rst_n, r_state == S_RUN, (r_pend & ~$past(r_pend)) == '0)
    `PEQ_ASSERT_NEXT(a_one_filter_done, i_clk, i_rst_n, (r_state == S_RUN) && (r_pend != '0) && (r_step == STEP_WB), ($countones(r_pend) + 1) == $countones($past(r_pend)))
    `PEQ_ASSERT_NOW(a_step_parked, i_clk, i_rst_n, r_state != S_RUN, r_step == STEP_ISSUE)

endmodule

/* rtl/parallel_biquad_equalizer.sv */
// ----------------------------------------------------------------------------
// Parallel biquad equalizer
// High-pass, low-pass and parallel band biquads on a shared multiplier.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                 Payload
//  input     in         i_in_valid / o_in_stall   i_in_sample, i_in_channel
//  output    out        o_out_valid / i_out_stall o_out_sample, o_out_channel
//  config    in         APB psel/penable/pwrite   paddr, pwdata, prdata
//
// A filtered sample runs each enabled filter in turn, up to all six; a
// pass-through sample runs none.
// Each biquad runs five products through the single 32x32 multiplier, and its
// schedule also covers the coefficient read and the product register.
// Reset restores the register defaults and clears the filter state valid bits,
// so no clearing pass is needed.
// A new sample is taken while a finished one waits in the output register; a
// stalled result holds until its transfer.
// ----------------------------------------------------------------------------
module parallel_biquad_equalizer
    import peq_pkg::*;
#(
    parameter int NUM_BANDS    = DEF_NUM_BANDS,
    parameter int NUM_CHANNELS = DEF_NUM_CHANNELS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,
    output logic [APB_DW-1:0]   prdata,
    output logic                pready,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic signed [23:0]  i_in_sample,
    input  logic                i_in_channel,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic signed [23:0]  o_out_sample,
    output logic                o_out_channel
);

    localparam int FILTERS    = FIRST_BAND + NUM_BANDS;
    localparam int COEF_DEPTH = FILTERS * COEFS_PER_FILTER;
    localparam int COEF_AW    = $clog2(COEF_DEPTH);
    localparam int ROWS       = FILTERS * NUM_CHANNELS;
    localparam int ROW_AW     = $clog2(ROWS);

    t_cfg               cfg;
    t_mac_ctl           ctl;
    logic [COEF_AW-1:0] coef_addr;
    logic [ROW_AW-1:0]  row;
    logic signed [31:0] coef;

    peq_cfg #(
        .NUM_BANDS (NUM_BANDS)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_cfg       (cfg),
        .i_coef_addr (coef_addr),
        .o_coef      (coef)
    );

    peq_seq #(
        .NUM_BANDS    (NUM_BANDS),
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_in_channel  (i_in_channel),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_channel (o_out_channel),
        .i_cfg         (cfg),
        .o_coef_addr   (coef_addr),
        .o_row         (row),
        .o_ctl         (ctl)
    );

    peq_mac #(
        .NUM_BANDS    (NUM_BANDS),
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_mac (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (ctl),
        .i_row        (row),
        .i_coef       (coef),
        .i_in_sample  (i_in_sample),
        .o_out_sample (o_out_sample)
    );

endmodule
